[rtl/zfhwc_pkg.sv]
// Shared types, constants and helper functions for the frame header window check.
// Used by zfhwc_step and by the top level zstd_frame_header_window_check.
package zfhwc_pkg;

  localparam int unsigned PROBE_BYTES = 18;

  localparam logic [31:0] MAGIC_REGULAR   = 32'hFD2F_B528;
  localparam logic [31:0] MAGIC_SKIP_MASK = 32'hFFFF_FFF0;
  localparam logic [31:0] MAGIC_SKIP_BASE = 32'h184D_2A50;
  localparam logic [7:0]  DESC_SS_FLAG    = 8'h20;
  localparam logic [31:0] MAX_WINDOW_RESET = 32'd8 * 32'd1024 * 32'd1024;
  localparam logic [63:0] FCS2_OFFSET     = 64'd256;

  typedef enum logic [2:0] {
    VERDICT_REGULAR_OK = 3'd0,
    VERDICT_SKIP_OK    = 3'd1,
    VERDICT_TOO_SMALL  = 3'd2,
    VERDICT_BAD_MAGIC  = 3'd3,
    VERDICT_TRUNCATED  = 3'd4,
    VERDICT_TOO_LARGE  = 3'd5
  } verdict_t;

  // Per-file header state.
  typedef struct packed {
    logic [4:0]  byte_count;
    logic [31:0] magic_word;
    logic [7:0]  descriptor;
    logic [63:0] window_accum;
    logic        decided;
  } hdr_state_t;

  // One result word.
  typedef struct packed {
    logic        valid;
    verdict_t    verdict;
    logic [63:0] window;
  } hdr_result_t;

  // Length in bytes of the dictionary id field.
  function automatic logic [4:0] dict_id_len(input logic [1:0] code);
    logic [4:0] len;
    case (code)
      2'd0:    len = 5'd0;
      2'd1:    len = 5'd1;
      2'd2:    len = 5'd2;
      default: len = 5'd4;
    endcase
    return len;
  endfunction

  // Length in bytes of the content size field in single-segment mode.
  function automatic logic [4:0] fcs_len(input logic [1:0] code);
    logic [4:0] len;
    case (code)
      2'd0:    len = 5'd1;
      2'd1:    len = 5'd2;
      2'd2:    len = 5'd4;
      default: len = 5'd8;
    endcase
    return len;
  endfunction

  // Window from the exponent and mantissa byte. The mantissa adds eighths of the base,
  // built from shifted copies of one eighth.
  function automatic logic [63:0] window_from_desc(input logic [7:0] wd);
    logic [63:0] base;
    logic [63:0] step;
    base = 64'd1 << (6'd10 + {1'b0, wd[7:3]});
    step = base >> 3;
    return base + (wd[0] ? step : 64'd0) + (wd[1] ? (step << 1) : 64'd0)
         + (wd[2] ? (step << 2) : 64'd0);
  endfunction

endpackage

[rtl/zfhwc_step.sv]
// Combinational per-byte header update: next state and optional verdict.
// Depends on zfhwc_pkg for the state and result types and the decode helpers.
module zfhwc_step (
  input  zfhwc_pkg::hdr_state_t  st,
  input  logic [7:0]             data_byte,
  input  logic                   is_last,
  input  logic [31:0]            max_window,
  output zfhwc_pkg::hdr_state_t  st_next,
  output zfhwc_pkg::hdr_result_t res
);
  import zfhwc_pkg::*;

  logic [4:0]  pos;
  logic        active;
  logic [31:0] magic_new;
  logic [4:0]  off;
  logic [4:0]  fcs;
  logic [4:0]  rel;
  logic        in_field;
  logic        judge_en;
  logic [63:0] judge_w;
  logic [63:0] accum_new;

  assign pos       = st.byte_count;
  assign active    = !st.decided && (pos < 5'(PROBE_BYTES));
  assign magic_new = st.magic_word | (32'(data_byte) << {pos[1:0], 3'b000});
  assign off       = 5'd5 + dict_id_len(st.descriptor[1:0]);
  assign fcs       = fcs_len(st.descriptor[7:6]);
  assign rel       = pos - off;
  assign in_field  = (pos >= off) && (rel < fcs);
  assign accum_new = st.window_accum | (64'(data_byte) << {rel[2:0], 3'b000});

  always_comb begin
    st_next     = st;
    res.valid   = 1'b0;
    res.verdict = VERDICT_REGULAR_OK;
    res.window  = '0;
    judge_en    = 1'b0;
    judge_w     = '0;

    if (active) begin
      st_next.byte_count = pos + 5'd1;
      if (pos < 5'd4) begin
        st_next.magic_word = magic_new;
        if (pos == 5'd3 && magic_new != MAGIC_REGULAR) begin
          res.valid   = 1'b1;
          res.verdict = ((magic_new & MAGIC_SKIP_MASK) == MAGIC_SKIP_BASE) ?
                        VERDICT_SKIP_OK : VERDICT_BAD_MAGIC;
        end
      end else if (pos == 5'd4) begin
        st_next.descriptor = data_byte;
      end else if ((st.descriptor & DESC_SS_FLAG) == 8'h00) begin
        judge_en = 1'b1;
        judge_w  = window_from_desc(data_byte);
      end else if (in_field) begin
        st_next.window_accum = accum_new;
        if (rel == fcs - 5'd1) begin
          judge_en = 1'b1;
          judge_w  = (fcs == 5'd2) ? accum_new + FCS2_OFFSET : accum_new;
        end
      end
    end

    if (judge_en) begin
      res.valid   = 1'b1;
      res.window  = judge_w;
      res.verdict = (judge_w > {32'd0, max_window}) ? VERDICT_TOO_LARGE : VERDICT_REGULAR_OK;
    end

    if (res.valid) begin
      st_next.decided = 1'b1;
    end

    // The end mark closes the file: a pending file gets its verdict and all state clears.
    if (is_last) begin
      if (!st.decided && !res.valid) begin
        res.valid   = 1'b1;
        res.window  = '0;
        res.verdict = (st_next.byte_count < 5'd4) ? VERDICT_TOO_SMALL : VERDICT_TRUNCATED;
      end
      st_next = '0;
    end
  end

endmodule

[rtl/zstd_frame_header_window_check.sv]
// Top level of the frame header window check: input word register, header state,
// result register and the max_window configuration register. Uses zfhwc_pkg and zfhwc_step.
//
// Usage:
//   The input channel (in_valid, in_ready, data_byte, is_last) carries one file byte per
//   word, starting at offset zero; is_last marks the file's final byte. The output channel
//   (out_valid, out_ready, verdict, declared_window) carries at most one word per file: the
//   verdict, given at the byte that decides it or at the end mark. Bytes after the verdict
//   are dropped until the end mark, which returns the header state to its reset value so
//   the next byte opens a new file.
//   The configuration channel (cfg_valid, cfg_ready, cfg_data) writes max_window; it is
//   always ready and should only be written while no file bytes are in flight.
// Timing:
//   An accepted byte lands in the input register; the header update then runs on it
//   combinationally and any verdict is captured in the result register, which drives
//   out_valid. One byte is taken every cycle while no verdict waits on a full result
//   register; the only loop is the header state register and its combinational update.
// Reset:
//   rst (synchronous, active high) empties both registers, clears the header state and
//   loads max_window with 8 MiB.
// Stalls:
//   While out_ready is low a waiting verdict holds. Bytes that produce no verdict still
//   flow through; a byte that would produce a verdict waits in the input register, and
//   in_ready then drops until the result word is taken.
module zstd_frame_header_window_check (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  input  logic                 is_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output zfhwc_pkg::verdict_t  verdict,
  output logic [63:0]          declared_window,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_data
);
  import zfhwc_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        s1_adv;
  logic [31:0] max_window;
  hdr_state_t  hdr;
  hdr_state_t  hdr_next;
  hdr_result_t res;

  zfhwc_step u_step (
    .st        (hdr),
    .data_byte (s1_byte),
    .is_last   (s1_last),
    .max_window(max_window),
    .st_next   (hdr_next),
    .res       (res)
  );

  // The registered byte moves on when it yields nothing or the result slot is free.
  assign s1_adv    = s1_valid && (!res.valid || !out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
      s1_last <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr <= '0;
    end else if (s1_adv) begin
      hdr <= hdr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_adv && res.valid) begin
      verdict         <= res.verdict;
      declared_window <= res.window;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_window <= MAX_WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_window <= cfg_data;
    end
  end

  // Only regular-frame verdicts carry a window.
  a_window_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict != VERDICT_REGULAR_OK && verdict != VERDICT_TOO_LARGE
    |-> declared_window == 64'd0)
    else $error("window set on a verdict that carries none");

  // A result word is written only from a byte that advances.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    !out_valid |=> !out_valid || $past(s1_adv && res.valid))
    else $error("result word appeared without a deciding byte");

  // The header byte count never runs past the probe bound.
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    hdr.byte_count <= 5'(PROBE_BYTES))
    else $error("byte count beyond probe bound");

  // An end mark returns the header state to reset.
  a_file_clear: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_last |=> hdr.byte_count == 5'd0 && !hdr.decided && hdr.magic_word == 32'd0)
    else $error("header state not cleared after end mark");

  // A file that has been decided yields no further verdict.
  a_single_verdict: assert property (@(posedge clk) disable iff (rst)
    s1_valid && hdr.decided |-> !res.valid)
    else $error("second verdict for one file");

endmodule
